@@ sv/c3f_pkg.sv @@
// Shared types, codes and arithmetic constants of the 3x3 image filter.
package c3f_pkg;

   localparam int MASK_TAPS = 9;
   localparam int PIX_W     = 8;
   localparam int COORD_W   = 10;
   localparam int SIZE_W    = 11;
   localparam int MIN_SIZE  = 3;

   // convolution sum and its magnitude
   localparam int SUM_W = 14;
   localparam int MAG_W = 12;

   // normalization datapath
   localparam int NUM_W   = 15;
   localparam int EST_W   = 12;
   localparam int DIV_W   = 5;
   localparam int RECIP_W = 14;
   localparam int PROD_W  = NUM_W + RECIP_W;

   localparam logic [DIV_W-1:0]   DIV_BOX         = 5'd18;
   localparam logic [DIV_W-1:0]   DIV_WEIGHTED    = 5'd16;
   localparam logic [DIV_W-1:0]   DIV_SHARPEN     = 5'd6;
   localparam logic [RECIP_W-1:0] RECIP_BOX       = 14'd3640;
   localparam logic [RECIP_W-1:0] RECIP_SHARPEN   = 14'd10922;
   localparam int                 RECIP_SHIFT     = 16;
   localparam int                 WEIGHTED_SHIFT  = 4;
   localparam logic [NUM_W-1:0]   ROUND_BOX       = 15'd9;
   localparam logic [NUM_W-1:0]   ROUND_WEIGHTED  = 15'd8;
   localparam logic [NUM_W-1:0]   ROUND_SHARPEN   = 15'd3;
   localparam logic [EST_W-1:0]   PIX_MAX         = 12'd255;

   typedef enum logic [1:0] {
      MODE_BOX      = 2'd0,
      MODE_WEIGHTED = 2'd1,
      MODE_SHARPEN  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      REG_FILTER_MODE  = 2'd0,
      REG_IMAGE_WIDTH  = 2'd1,
      REG_IMAGE_HEIGHT = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               last;
   } coord_type;

   // the spare mode code falls back to the box mask
   function automatic mode_type decode_mode(input logic [1:0] code);
      mode_type m;
      case (code)
         MODE_WEIGHTED: m = MODE_WEIGHTED;
         MODE_SHARPEN:  m = MODE_SHARPEN;
         default:       m = MODE_BOX;
      endcase
      return m;
   endfunction

endpackage

@@ sv/conv3x3_image_filter_core.sv @@
// Top level of the streaming 3x3 image filter: position counters, CSRs and pipeline.
//
// Streaming 3x3 convolution on one 8-bit channel. Samples enter in raster order at one
// per clock while the output is not stalled; the limit is the line memory, which takes one read and one write
// per cycle. A result leaves five stages after its sample is accepted (input/memory read,
// window, convolution, quotient estimate, result register). Border pixels give no result.
// filter_mode selects box (norm 9), weighted 1-2-1 (norm 16) or Laplacian sharpen (norm
// 1.2); the output is |sum|/norm rounded half away from zero and clipped to 255. Sizes
// are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT; frame_start restarts the position
// counters. Line memory contents are undefined after reset and need no clearing; change
// the CSRs only while the pipeline is empty.
module conv3x3_image_filter_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_sample,
   input  logic         req_frame_start,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [7:0]   rsp_filtered,
   output logic [9:0]   rsp_out_col,
   output logic [9:0]   rsp_out_row,
   output logic         rsp_frame_last,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import c3f_pkg::*;

   localparam int WW  = $clog2(MAX_WIDTH) + 1;
   localparam int HW  = $clog2(MAX_HEIGHT) + 1;
   localparam int CW  = WW - 1;
   localparam int SWW = (WW > SIZE_W) ? WW : SIZE_W;
   localparam int SHW = (HW > SIZE_W) ? HW : SIZE_W;

   // configuration
   logic [1:0]        mode_ff;
   logic [SIZE_W-1:0] width_ff;
   logic [SIZE_W-1:0] height_ff;
   logic              csr_write;
   logic [SWW-1:0]    width_ext;
   logic [SHW-1:0]    height_ext;
   logic [WW-1:0]     w_lim;
   logic [HW-1:0]     h_lim;
   mode_type          mode;

   // position
   logic [WW-1:0]     col_cnt_ff;
   logic [WW-1:0]     col_cnt_in;
   logic [HW-1:0]     row_cnt_ff;
   logic [HW-1:0]     row_cnt_in;
   logic [WW-1:0]     col;
   logic [HW-1:0]     row;
   logic [WW-1:0]     col_next;
   logic [HW-1:0]     row_next;
   logic              emit;
   coord_type         coord;

   // input stage
   logic              accept;
   logic              b_valid_ff;
   logic [PIX_W-1:0]  sample_b_ff;
   logic [CW-1:0]     addr_b_ff;
   logic              emit_b_ff;
   coord_type         coord_b_ff;
   logic              b_leave;
   logic [15:0]       rd_data;
   logic              win_ready;

   // between convolution and normalization
   logic              sum_valid;
   logic              sum_ready;
   logic [MAG_W-1:0]  sum_mag;
   coord_type         sum_coord;
   coord_type         rsp_coord;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_BOX;
         width_ff  <= SIZE_W'(1024);
         height_ff <= SIZE_W'(1024);
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_FILTER_MODE:  mode_ff   <= csr_pwdata[1:0];
            REG_IMAGE_WIDTH:  width_ff  <= csr_pwdata[SIZE_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_FILTER_MODE:  csr_prdata = 32'(mode_ff);
         REG_IMAGE_WIDTH:  csr_prdata = 32'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = 32'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // clamp the frame size to the supported range
   always_comb begin
      width_ext  = SWW'(width_ff);
      height_ext = SHW'(height_ff);
      if (width_ext < SWW'(MIN_SIZE)) begin
         w_lim = WW'(MIN_SIZE);
      end else if (width_ext > SWW'(MAX_WIDTH)) begin
         w_lim = WW'(MAX_WIDTH);
      end else begin
         w_lim = WW'(width_ext);
      end
      if (height_ext < SHW'(MIN_SIZE)) begin
         h_lim = HW'(MIN_SIZE);
      end else if (height_ext > SHW'(MAX_HEIGHT)) begin
         h_lim = HW'(MAX_HEIGHT);
      end else begin
         h_lim = HW'(height_ext);
      end
   end

   assign mode = decode_mode(mode_ff);

   // position of the incoming beat and of the one after it
   always_comb begin
      col = req_frame_start ? '0 : col_cnt_ff;
      row = req_frame_start ? '0 : row_cnt_ff;
      if (col >= w_lim) begin
         col = '0;
         row = row + 1'b1;
      end
      if (row >= h_lim) begin
         row = '0;
      end
      col_next = col + 1'b1;
      row_next = row + 1'b1;
      if (col_next >= w_lim) begin
         col_cnt_in = '0;
         row_cnt_in = (row_next >= h_lim) ? '0 : row_next;
      end else begin
         col_cnt_in = col_next;
         row_cnt_in = row;
      end
      emit       = (col >= WW'(2)) && (row >= HW'(2));
      coord.col  = COORD_W'(col - 1'b1);
      coord.row  = COORD_W'(row - 1'b1);
      coord.last = (col == w_lim - 1'b1) && (row == h_lim - 1'b1);
   end

   assign req_ready = !b_valid_ff || win_ready;
   assign accept    = req_valid && req_ready;
   assign b_leave   = b_valid_ff && win_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_cnt_ff <= col_cnt_in;
            row_cnt_ff <= row_cnt_in;
            b_valid_ff <= 1'b1;
         end else if (win_ready) begin
            b_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_b_ff <= req_sample;
         addr_b_ff   <= col[CW-1:0];
         emit_b_ff   <= emit;
         coord_b_ff  <= coord;
      end
   end

   c3f_line_store #(
      .DEPTH   (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col[CW-1:0]),
      .rd_data (rd_data),
      .wr_en   (b_leave),
      .wr_addr (addr_b_ff),
      .wr_data ({rd_data[7:0], sample_b_ff})
   );

   c3f_window_sum u_window_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid_ff),
      .in_ready  (win_ready),
      .col_top   (rd_data[15:8]),
      .col_mid   (rd_data[7:0]),
      .col_bot   (sample_b_ff),
      .in_emit   (emit_b_ff),
      .in_coord  (coord_b_ff),
      .mode      (mode),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_mag   (sum_mag),
      .out_coord (sum_coord)
   );

   c3f_normalize u_normalize (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (sum_valid),
      .in_ready     (sum_ready),
      .in_mag       (sum_mag),
      .in_coord     (sum_coord),
      .mode         (mode),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_filtered (rsp_filtered),
      .out_coord    (rsp_coord)
   );

   assign rsp_out_col    = rsp_coord.col;
   assign rsp_out_row    = rsp_coord.row;
   assign rsp_frame_last = rsp_coord.last;

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_frame_start |=> addr_b_ff == '0 && !emit_b_ff)
      else $error("frame start did not restart the column");

   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      col_cnt_ff < WW'(MAX_WIDTH) && row_cnt_ff < HW'(MAX_HEIGHT))
      else $error("position counter beyond the line memory");

endmodule

@@ sv/c3f_line_store.sv @@
// Line memory holding the two previous lines, one read and one write per cycle.
module c3f_line_store #(
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [15:0]   rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [15:0]   wr_data
);
   import c3f_pkg::*;

   // upper byte: two lines above, lower byte: line above
   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // forward a write that lands on the address being read in the same cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/c3f_window_sum.sv @@
// 3x3 window registers and the mask convolution stage.
module c3f_window_sum (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [c3f_pkg::PIX_W-1:0]    col_top,
   input  logic [c3f_pkg::PIX_W-1:0]    col_mid,
   input  logic [c3f_pkg::PIX_W-1:0]    col_bot,
   input  logic                         in_emit,
   input  c3f_pkg::coord_type           in_coord,
   input  c3f_pkg::mode_type            mode,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [c3f_pkg::MAG_W-1:0]    out_mag,
   output c3f_pkg::coord_type           out_coord
);
   import c3f_pkg::*;

   logic [PIX_W-1:0]        win_ff [MASK_TAPS];
   logic [PIX_W-1:0]        win_in [MASK_TAPS];
   logic                    w_valid_ff;
   coord_type               w_coord_ff;
   logic                    s_valid_ff;
   logic [MAG_W-1:0]        mag_ff;
   logic [MAG_W-1:0]        mag_in;
   coord_type               s_coord_ff;
   logic                    s_ready;
   logic                    load_w;
   logic                    load_s;
   logic [9:0]              corner_sum;
   logic [9:0]              side_sum;
   logic [SUM_W-1:0]        center;
   logic signed [SUM_W-1:0] sum;

   assign s_ready  = !s_valid_ff || out_ready;
   assign in_ready = !w_valid_ff || s_ready;
   assign load_w   = in_valid && in_ready;
   assign load_s   = w_valid_ff && s_ready;

   // shift left, new column enters on the right
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k*3]     = win_ff[k*3+1];
         win_in[k*3+1]   = win_ff[k*3+2];
         win_in[k*3+2]   = win_ff[k*3+2];
      end
      win_in[2] = col_top;
      win_in[5] = col_mid;
      win_in[8] = col_bot;
   end

   always_comb begin
      corner_sum = 10'(win_ff[0]) + 10'(win_ff[2]) + 10'(win_ff[6]) + 10'(win_ff[8]);
      side_sum   = 10'(win_ff[1]) + 10'(win_ff[3]) + 10'(win_ff[5]) + 10'(win_ff[7]);
      center     = SUM_W'(win_ff[4]);
      case (mode)
         MODE_WEIGHTED: sum = SUM_W'(corner_sum) + (SUM_W'(side_sum) << 1) + (center << 2);
         MODE_SHARPEN:  sum = (center << 2) + center - SUM_W'(side_sum);
         default:       sum = SUM_W'(corner_sum) + SUM_W'(side_sum) + center;
      endcase
      mag_in = sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MASK_TAPS; k++) begin
            win_ff[k] <= '0;
         end
         w_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
      end else begin
         if (load_w) begin
            win_ff     <= win_in;
            w_valid_ff <= in_emit;
         end else if (load_s) begin
            w_valid_ff <= 1'b0;
         end
         if (load_s) begin
            s_valid_ff <= 1'b1;
         end else if (out_ready) begin
            s_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_w) begin
         w_coord_ff <= in_coord;
      end
      if (load_s) begin
         mag_ff     <= mag_in;
         s_coord_ff <= w_coord_ff;
      end
   end

   assign out_valid = s_valid_ff;
   assign out_mag   = mag_ff;
   assign out_coord = s_coord_ff;

   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      s_valid_ff |-> mag_ff <= MAG_W'(4080))
      else $error("convolution magnitude out of range");

endmodule

@@ sv/c3f_normalize.sv @@
// Division by the mask norm with rounding, saturation and the result register.
module c3f_normalize (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [c3f_pkg::MAG_W-1:0]     in_mag,
   input  c3f_pkg::coord_type            in_coord,
   input  c3f_pkg::mode_type             mode,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [c3f_pkg::PIX_W-1:0]     out_filtered,
   output c3f_pkg::coord_type            out_coord
);
   import c3f_pkg::*;

   logic                q_valid_ff;
   logic [NUM_W-1:0]    x_ff;
   logic [NUM_W-1:0]    x_in;
   logic [EST_W-1:0]    est_ff;
   logic [EST_W-1:0]    est_in;
   logic [DIV_W-1:0]    div_ff;
   logic [DIV_W-1:0]    div_in;
   coord_type           q_coord_ff;
   logic [RECIP_W-1:0]  recip;
   logic [PROD_W-1:0]   prod;
   logic                o_valid_ff;
   logic [PIX_W-1:0]    filtered_ff;
   logic [PIX_W-1:0]    filtered_in;
   coord_type           o_coord_ff;
   logic [NUM_W-1:0]    rem;
   logic [EST_W-1:0]    quot;
   logic                o_ready;
   logic                load_q;
   logic                load_o;

   assign o_ready  = !o_valid_ff || out_ready;
   assign in_ready = !q_valid_ff || o_ready;
   assign load_q   = in_valid && in_ready;
   assign load_o   = q_valid_ff && o_ready;

   // quotient estimate by reciprocal, or by shift for the weighted mask, never above the true quotient
   always_comb begin
      case (mode)
         MODE_WEIGHTED: begin
            x_in   = NUM_W'(in_mag) + ROUND_WEIGHTED;
            recip  = '0;
            div_in = DIV_WEIGHTED;
         end
         MODE_SHARPEN: begin
            x_in   = (NUM_W'(in_mag) << 2) + NUM_W'(in_mag) + ROUND_SHARPEN;
            recip  = RECIP_SHARPEN;
            div_in = DIV_SHARPEN;
         end
         default: begin
            x_in   = (NUM_W'(in_mag) << 1) + ROUND_BOX;
            recip  = RECIP_BOX;
            div_in = DIV_BOX;
         end
      endcase
      prod = PROD_W'(x_in) * PROD_W'(recip);
      if (mode == MODE_WEIGHTED) begin
         est_in = EST_W'(x_in >> WEIGHTED_SHIFT);
      end else begin
         est_in = EST_W'(prod >> RECIP_SHIFT);
      end
   end

   // correct the estimate by one step, then clip to the pixel range
   always_comb begin
      rem  = x_ff - NUM_W'(NUM_W'(div_ff) * NUM_W'(est_ff));
      quot = est_ff + EST_W'(rem >= NUM_W'(div_ff));
      filtered_in = (quot > PIX_MAX) ? PIX_MAX[PIX_W-1:0] : quot[PIX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (load_q) begin
            q_valid_ff <= 1'b1;
         end else if (o_ready) begin
            q_valid_ff <= 1'b0;
         end
         if (load_o) begin
            o_valid_ff <= 1'b1;
         end else if (out_ready) begin
            o_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_q) begin
         x_ff       <= x_in;
         est_ff     <= est_in;
         div_ff     <= div_in;
         q_coord_ff <= in_coord;
      end
      if (load_o) begin
         filtered_ff <= filtered_in;
         o_coord_ff  <= q_coord_ff;
      end
   end

   assign out_valid    = o_valid_ff;
   assign out_filtered = filtered_ff;
   assign out_coord    = o_coord_ff;

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      q_valid_ff |-> rem < (NUM_W'(div_ff) << 1))
      else $error("quotient estimate off by more than one");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the streaming 3x3 image filter core.
`timescale 1ns / 1ps

module tb_top;
   import c3f_pkg::*;

   localparam int          FRAME_MAX_W    = 1024;
   localparam int          FRAME_MAX_H    = 1024;
   localparam int          SETTLE_CYCLES  = 12;
   localparam int          LONG_HOLD      = 400;
   localparam int unsigned RANDOM_PIXELS  = 850;
   localparam int unsigned EXTREME_PIXELS = 60;
   localparam longint      TIMEOUT_NS     = 5_000_000;
   localparam logic [1:0]  MODE_SPARE     = 2'd3;

   typedef struct {
      logic [PIX_W-1:0]   filtered;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               last;
   } filtered_pixel_type;

   logic         clock           = 1'b0;
   logic         reset           = 1'b1;
   logic         req_valid       = 1'b0;
   logic         req_ready;
   logic [7:0]   req_sample      = '0;
   logic         req_frame_start = 1'b0;
   logic         rsp_valid;
   logic         rsp_ready       = 1'b0;
   logic [7:0]   rsp_filtered;
   logic [9:0]   rsp_out_col;
   logic [9:0]   rsp_out_row;
   logic         rsp_frame_last;
   logic         csr_psel        = 1'b0;
   logic         csr_penable     = 1'b0;
   logic         csr_pwrite      = 1'b0;
   logic [3:0]   csr_paddr       = '0;
   logic [31:0]  csr_pwdata      = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   // traffic shaping
   int unsigned  idle_pct      = 0;
   int unsigned  stall_pct     = 0;
   int unsigned  hold_requests = 0;
   int unsigned  hold_grants   = 0;
   int           hold_left     = 0;

   // run statistics
   int unsigned  pixels_sent     = 0;
   int unsigned  results_checked = 0;
   int unsigned  mismatch_count  = 0;

   // filter state as the block should hold it
   logic [1:0]        cfg_mode   = MODE_BOX;
   logic [SIZE_W-1:0] cfg_width  = 11'd1024;
   logic [SIZE_W-1:0] cfg_height = 11'd1024;
   logic [7:0]        line_above     [FRAME_MAX_W];
   logic [7:0]        line_two_above [FRAME_MAX_W];
   int                win [MASK_TAPS] = '{default: 0};
   int unsigned       next_col = 0;
   int unsigned       next_row = 0;
   filtered_pixel_type expected_pixels [$];

   conv3x3_image_filter_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_filtered    (rsp_filtered),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_row     (rsp_out_row),
      .rsp_frame_last  (rsp_frame_last),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned effective_size(input logic [SIZE_W-1:0] v,
                                                  input int unsigned hi);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > hi) return hi;
      return v;
   endfunction

   // Advance the window by one accepted pixel; queue the filtered pixel if interior.
   task automatic predict_pixel(input logic [7:0] pix, input logic fs);
      int unsigned        w, h, c, r, mag, q;
      int                 sum, k;
      mode_type           m;
      filtered_pixel_type res;
      w = effective_size(cfg_width, FRAME_MAX_W);
      h = effective_size(cfg_height, FRAME_MAX_H);
      if (fs) begin
         next_col = 0;
         next_row = 0;
      end
      // sizes may have shrunk under the counters
      if (next_col >= w) begin
         next_col = 0;
         next_row++;
      end
      if (next_row >= h) next_row = 0;
      c = next_col;
      r = next_row;
      for (k = 0; k < 3; k++) begin
         win[k*3]   = win[k*3+1];
         win[k*3+1] = win[k*3+2];
      end
      win[2] = line_two_above[c];
      win[5] = line_above[c];
      win[8] = pix;
      line_two_above[c] = line_above[c];
      line_above[c]     = pix;
      if (c >= 2 && r >= 2) begin
         m = (cfg_mode == MODE_WEIGHTED || cfg_mode == MODE_SHARPEN) ?
             mode_type'(cfg_mode) : MODE_BOX;
         case (m)
            MODE_WEIGHTED: begin
               sum = win[0] + 2*win[1] + win[2] + 2*win[3] + 4*win[4] + 2*win[5]
                   + win[6] + 2*win[7] + win[8];
               mag = sum;
               q   = (mag + 8) >> 4;
            end
            MODE_SHARPEN: begin
               sum = 5*win[4] - win[1] - win[3] - win[5] - win[7];
               mag = (sum < 0) ? -sum : sum;
               q   = (5*mag + 3) / 6;
            end
            default: begin
               sum = win[0] + win[1] + win[2] + win[3] + win[4] + win[5]
                   + win[6] + win[7] + win[8];
               mag = sum;
               q   = (2*mag + 9) / 18;
            end
         endcase
         res.filtered = (q > 255) ? 8'd255 : 8'(q);
         res.col      = COORD_W'(c - 1);
         res.row      = COORD_W'(r - 1);
         res.last     = (c == w - 1) && (r == h - 1);
         expected_pixels.push_back(res);
      end
      next_col = c + 1;
      if (next_col >= w) begin
         next_col = 0;
         next_row = r + 1;
         if (next_row >= h) next_row = 0;
      end
   endtask

   // Offer one pixel beat, after a random gap, and hold it until accepted.
   task automatic send_pixel(input logic [7:0] pix, input logic fs);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sample      <= pix;
      req_frame_start <= fs;
      do @(posedge clock); while (!req_ready);
      predict_pixel(pix, fs);
      pixels_sent++;
   endtask

   function automatic logic [7:0] random_pixel();
      case ($urandom_range(9))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_raster(input int unsigned count, input bit lead_start,
                              input int unsigned noise_pct);
      int unsigned i;
      for (i = 0; i < count; i++)
         send_pixel(random_pixel(), (i == 0) ? lead_start : ($urandom_range(99) < noise_pct));
   endtask

   task automatic write_csr(input reg_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_FILTER_MODE:  cfg_mode   = value[1:0];
         REG_IMAGE_WIDTH:  cfg_width  = value[SIZE_W-1:0];
         REG_IMAGE_HEIGHT: cfg_height = value[SIZE_W-1:0];
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // junk_high fills the unused upper bits, which the block must ignore
   task automatic configure(input logic [1:0] mode, input logic [SIZE_W-1:0] w,
                            input logic [SIZE_W-1:0] h, input bit junk_high = 1'b0);
      logic [31:0] upper;
      upper = junk_high ? $urandom : 32'd0;
      write_csr(REG_FILTER_MODE,  {upper[31:2], mode});
      write_csr(REG_IMAGE_WIDTH,  {upper[31:SIZE_W], w});
      write_csr(REG_IMAGE_HEIGHT, {upper[31:SIZE_W], h});
   endtask

   task automatic set_traffic(input int unsigned idle, input int unsigned stall);
      idle_pct  = idle;
      stall_pct = stall;
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   // let border pixels still in the pipe drain before touching the CSRs
   task automatic quiesce();
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed_corners();
      int k;
      set_traffic(0, 0);
      configure(MODE_BOX, 11'd3, 11'd3);
      for (k = 0; k < 9; k++) send_pixel(8'd255, k == 0);
      quiesce();
      // second frame runs on without frame_start; dark center, bright ring saturates
      configure(MODE_SHARPEN, 11'd3, 11'd3);
      for (k = 0; k < 9; k++) send_pixel((k == 4) ? 8'd0 : 8'd255, 1'b0);
      quiesce();
   endtask

   task automatic test_midline_resize();
      set_traffic(0, 0);
      configure(MODE_SPARE, 11'd4, 11'd4);
      send_raster(11, 1'b1, 0);
      quiesce();
      // column counter now sits at the new width: next pixel opens the next row
      write_csr(REG_IMAGE_WIDTH, 32'd3);
      send_raster(3, 1'b0, 0);
      quiesce();
   endtask

   task automatic test_output_backpressure();
      set_traffic(0, 0);
      configure(MODE_WEIGHTED, 11'd12, 11'd10);
      hold_requests <= hold_requests + 1;
      send_raster(120, 1'b1, 0);
      quiesce();
   endtask

   task automatic test_sender_pause();
      set_traffic(8, 8);
      configure(MODE_SHARPEN, 11'd9, 11'd7);
      send_raster(31, 1'b1, 0);
      wait_results();
      send_raster(32, 1'b0, 0);
      quiesce();
   endtask

   // oversize width and zero height, then too narrow and oversize height
   task automatic test_size_extremes();
      set_traffic(8, 8);
      configure(2'($urandom_range(3)), 11'd2047, 11'd0);
      send_raster(EXTREME_PIXELS, 1'b1, 0);
      quiesce();
      configure(2'($urandom_range(3)), 11'd2, 11'd2047);
      send_raster(EXTREME_PIXELS, 1'b1, 0);
      quiesce();
   endtask

   task automatic test_random_frames();
      int unsigned       sent, seg, frames, f, n, len;
      logic [SIZE_W-1:0] wv, hv;
      sent = 0;
      seg  = 0;
      while (sent < RANDOM_PIXELS) begin
         case (seg % 4)
            0:       set_traffic(0, 0);
            1:       set_traffic(86, 0);
            2:       set_traffic(0, 86);
            default: set_traffic(8, 8);
         endcase
         wv = SIZE_W'(($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 14));
         hv = SIZE_W'(($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 9));
         configure(2'($urandom_range(3)), wv, hv, 1'b1);
         n      = effective_size(wv, FRAME_MAX_W) * effective_size(hv, FRAME_MAX_H);
         frames = $urandom_range(1, 4);
         for (f = 0; f < frames; f++) begin
            case ($urandom_range(9))
               0: len = $urandom_range(1, n - 1);   // cut short
               default: len = n;
            endcase
            case ($urandom_range(9))
               1:       send_raster(len, 1'b1, 5);    // stray frame starts
               2:       send_raster(len, f == 0, 0);  // overrun into next frame
               default: send_raster(len, 1'b1, 0);
            endcase
            sent += len;
         end
         quiesce();
         seg++;
      end
   endtask

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_requests != hold_grants) begin
         hold_grants <= hold_requests;
         hold_left   <= LONG_HOLD;
         rsp_ready   <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic void report_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
      mismatch_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
   endfunction

   always @(posedge clock) begin
      filtered_pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (expected_pixels.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result expected none, got %0d at col %0d row %0d",
                     $time, rsp_filtered, rsp_out_col, rsp_out_row);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_filtered !== want.filtered)
               report_field("filtered", want.filtered, rsp_filtered);
            if (rsp_out_col !== want.col)
               report_field("out_col", want.col, rsp_out_col);
            if (rsp_out_row !== want.row)
               report_field("out_row", want.row, rsp_out_row);
            if (rsp_frame_last !== want.last)
               report_field("frame_last", want.last, rsp_frame_last);
         end
      end
   end

   initial begin
      int i;
      for (i = 0; i < FRAME_MAX_W; i++) begin
         line_above[i]     = 8'd0;
         line_two_above[i] = 8'd0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_midline_resize();
      test_output_backpressure();
      test_sender_pause();
      test_size_extremes();
      test_random_frames();
      quiesce();
      $display("Covered %0d pixels in, %0d filtered results compared", pixels_sent,
               results_checked);
      $display("All masks incl. spare code, tiny and oversize frame settings, resize, overrun");
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timeout with %0d results outstanding", expected_pixels.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
